@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ hw/rtl/hbd_pkg.sv @@
// ---------------------------------------------------------------------------
// hbd_pkg
// types, codes and helpers shared by the http body deframer
// ---------------------------------------------------------------------------
package hbd_pkg;

   localparam int COUNT_BITS = 32;
   localparam int LINE_CHARS = 64;
   localparam int LINE_BITS  = $clog2(LINE_CHARS);

   // request queue between front and back, and result queue
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   localparam logic [63:0] COUNT_MAX_W = 64'((65'd1 << COUNT_BITS) - 65'd1);

   // request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EOS   = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_CHUNKED_MODE   = 2'd0;
   localparam logic [1:0] CSR_LENGTH_KNOWN   = 2'd1;
   localparam logic [1:0] CSR_CONTENT_LENGTH = 2'd2;

   // body phase
   localparam logic [2:0] PH_CLOSE    = 3'd0;
   localparam logic [2:0] PH_COUNTED  = 3'd1;
   localparam logic [2:0] PH_SIZELINE = 3'd2;
   localparam logic [2:0] PH_DATA     = 3'd3;
   localparam logic [2:0] PH_TRAILER  = 3'd4;
   localparam logic [2:0] PH_DONE     = 3'd5;
   localparam logic [2:0] PH_ERROR    = 3'd6;

   // size line parse phase
   localparam logic [2:0] HX_SPACE  = 3'd0;
   localparam logic [2:0] HX_SIGN   = 3'd1;
   localparam logic [2:0] HX_ZERO   = 3'd2;
   localparam logic [2:0] HX_PREFIX = 3'd3;
   localparam logic [2:0] HX_DIGITS = 3'd4;
   localparam logic [2:0] HX_STOP   = 3'd5;

   // characters
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       body_done;
      logic       body_error;
   } rsp_item_type;

   typedef struct packed {
      logic        chunked_mode;
      logic        length_known;
      logic [31:0] content_length;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       is_nl;
      logic       is_cr;
      logic       is_ws;
      logic       is_plus;
      logic       is_minus;
      logic       is_zero;
      logic       is_x;
      logic       is_hex;
      logic [3:0] hex_val;
   } cmd_type;

   function automatic logic [COUNT_BITS-1:0] clamp_length(input logic [31:0] len);
      logic [63:0] wide;
      wide = 64'(len);
      if (wide > COUNT_MAX_W) return '1;
      return COUNT_BITS'(wide);
   endfunction

endpackage

@@ hw/rtl/http_body_deframer.sv @@
// a request passes the front queue, its result the result queue, which drives the rsp ports
// throughput: one request per cycle sustained, with both sides flowing
// the front queue and the result queue each hold two entries, so either side may stall alone
// reset: synchronous, active high; csr registers clear to zero, the body starts close delimited
// and both queues come up empty; no clearing pass, requests are taken right after reset
// ---------------------------------------------------------------------------
// http_body_deframer
// http/1.1 body deframer: length, close delimited and chunked transfer coding
// ---------------------------------------------------------------------------
module http_body_deframer (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  req_push,
   output logic                  req_full,
   input  hbd_pkg::req_item_type req_item,
   // result side
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output hbd_pkg::rsp_item_type rsp_item,
   // csr write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import hbd_pkg::*;

   // csr registers, read by the back end only when a start request is executed
   logic        chunked_mode_ff, chunked_mode_in;
   logic        length_known_ff, length_known_in;
   logic [31:0] content_length_ff, content_length_in;
   logic        csr_write;
   cfg_type     cfg;

   // front to back request queue
   logic        cq_valid;
   cmd_type     cq_cmd;
   logic        cq_pop;

   // csr writes are always accepted
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      chunked_mode_in   = chunked_mode_ff;
      length_known_in   = length_known_ff;
      content_length_in = content_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CHUNKED_MODE:   chunked_mode_in   = csr_wdata[0];
            CSR_LENGTH_KNOWN:   length_known_in   = csr_wdata[0];
            CSR_CONTENT_LENGTH: content_length_in = csr_wdata;
            // index beyond the register list is dropped
            default:            content_length_in = content_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff   <= 1'b0;
         length_known_ff   <= 1'b0;
         content_length_ff <= '0;
      end else begin
         chunked_mode_ff   <= chunked_mode_in;
         length_known_ff   <= length_known_in;
         content_length_ff <= content_length_in;
      end
   end

   always_comb begin
      cfg.chunked_mode   = chunked_mode_ff;
      cfg.length_known   = length_known_ff;
      cfg.content_length = content_length_ff;
   end

   // front: classifies each request byte (newline, cr, whitespace, sign, zero, x, hex digit)
   // and queues it
   hbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cq_valid (cq_valid),
      .cq_cmd   (cq_cmd),
      .cq_pop   (cq_pop)
   );

   // back: phase machine, size line hex accumulate with saturation, result queue;
   // it takes one queued request per cycle whenever the result queue has room
   hbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cq_valid  (cq_valid),
      .cq_cmd    (cq_cmd),
      .cq_pop    (cq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

@@ hw/rtl/hbd_front.sv @@
// ---------------------------------------------------------------------------
// hbd_front
// classifies incoming requests and holds them in a short queue
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  hbd_pkg::req_item_type req_item,
   output logic                  cq_valid,
   output hbd_pkg::cmd_type      cq_cmd,
   input  logic                  cq_pop
);
   import hbd_pkg::*;

   cmd_type               cmd;
   cmd_type               cq_mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  cq_cnt_ff, cq_cnt_in;
   logic                  push_ok;
   logic [7:0]            b;

   // byte classes used by the size line parser
   always_comb begin
      b            = req_item.data_byte;
      cmd.kind     = req_item.kind;
      cmd.data_byte = b;
      cmd.is_nl    = (b == CHAR_NL);
      cmd.is_cr    = (b == CHAR_CR);
      cmd.is_ws    = (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
      cmd.is_plus  = (b == CHAR_PLUS);
      cmd.is_minus = (b == CHAR_MINUS);
      cmd.is_zero  = (b == CHAR_ZERO);
      cmd.is_x     = (b == CHAR_X_LO) || (b == CHAR_X_UP);
      cmd.is_hex   = 1'b1;
      cmd.hex_val  = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         cmd.hex_val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         cmd.hex_val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         cmd.hex_val = 4'(b - 8'h37);
      end else begin
         cmd.is_hex = 1'b0;
      end
   end

   assign req_full = (cq_cnt_ff == QCNT_BITS'(QDEPTH));
   assign push_ok  = req_push && !req_full;
   assign cq_valid = (cq_cnt_ff != '0);
   assign cq_cmd   = cq_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cq_cnt_in = cq_cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (cq_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push_ok && !cq_pop) begin
         cq_cnt_in = cq_cnt_ff + QCNT_BITS'(1);
      end else if (!push_ok && cq_pop) begin
         cq_cnt_in = cq_cnt_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cq_cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cq_cnt_ff <= cq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         cq_mem_ff[wr_ptr_ff] <= cmd;
      end
   end

   `ASSERT_ALWAYS(a_cq_bound, clock, reset, cq_cnt_ff <= QCNT_BITS'(QDEPTH))
   `ASSERT_IMPLIES(a_cq_pop_nonempty, clock, reset, cq_pop, cq_cnt_ff != '0)

endmodule

@@ hw/rtl/hbd_back.sv @@
// ---------------------------------------------------------------------------
// hbd_back
// body phase machine, size line parser and result queue
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hbd_pkg::cfg_type      cfg,
   input  logic                  cq_valid,
   input  hbd_pkg::cmd_type      cq_cmd,
   output logic                  cq_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output hbd_pkg::rsp_item_type rsp_item
);
   import hbd_pkg::*;

   logic [2:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [LINE_BITS-1:0]  line_len_ff, line_len_in;
   logic [2:0]            hx_ff, hx_in;
   logic                  neg_ff, neg_in;
   logic                  saw_nl_ff, saw_nl_in;

   rsp_item_type          rq_mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]  rq_wr_ff, rq_wr_in;
   logic [QPTR_BITS-1:0]  rq_rd_ff, rq_rd_in;
   logic [QCNT_BITS-1:0]  rq_cnt_ff, rq_cnt_in;

   logic                  room;
   logic                  fire;
   logic                  rsp_take;
   logic                  valid_in;
   logic [COUNT_BITS-1:0] rem_dec;
   logic [COUNT_BITS-1:0] rem_acc;
   logic [COUNT_BITS-1:0] start_len;
   rsp_item_type          result;
   logic                  start_chunked;
   logic                  fwd_phase;

   assign rsp_take  = rsp_pop && (rq_cnt_ff != '0);
   assign room      = (rq_cnt_ff != QCNT_BITS'(QDEPTH)) || rsp_take;
   assign fire      = cq_valid && room;
   assign cq_pop    = fire;
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp_item  = rq_mem_ff[rq_rd_ff];

   assign rem_dec   = (rem_ff != '0) ? rem_ff - COUNT_BITS'(1) : rem_ff;
   // saturate once a further digit would not fit
   assign rem_acc   = (rem_ff[COUNT_BITS-1 -: 4] != 4'd0) ? '1
                      : {rem_ff[COUNT_BITS-5:0], cq_cmd.hex_val};
   assign start_len = clamp_length(cfg.content_length);

   // phases in which body bytes pass through
   assign fwd_phase     = (phase_ff == PH_CLOSE) || (phase_ff == PH_COUNTED) ||
                          (phase_ff == PH_DATA);
   assign start_chunked = fire && (cq_cmd.kind == KIND_START) && cfg.chunked_mode;

   always_comb begin
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      line_len_in = line_len_ff;
      hx_in       = hx_ff;
      neg_in      = neg_ff;
      saw_nl_in   = saw_nl_ff;
      valid_in    = 1'b0;
      unique case (cq_cmd.kind)
         KIND_BYTE: begin
            unique case (phase_ff)
               PH_CLOSE: valid_in = 1'b1;
               PH_COUNTED: begin
                  valid_in = 1'b1;
                  rem_in   = rem_dec;
                  if (rem_dec == '0) phase_in = PH_DONE;
               end
               PH_SIZELINE: begin
                  if (cq_cmd.is_nl) begin
                     if (line_len_ff != '0) begin
                        if (neg_ff && rem_ff != '0) begin
                           phase_in = PH_ERROR;
                        end else if (rem_ff == '0) begin
                           phase_in  = PH_TRAILER;
                           saw_nl_in = 1'b1;
                        end else begin
                           phase_in = PH_DATA;
                        end
                        line_len_in = '0;
                        hx_in       = HX_SPACE;
                        neg_in      = 1'b0;
                     end
                  end else if (!cq_cmd.is_cr &&
                               line_len_ff < LINE_BITS'(LINE_CHARS - 1)) begin
                     line_len_in = line_len_ff + LINE_BITS'(1);
                     case (hx_ff)
                        HX_SPACE, HX_SIGN: begin
                           if (hx_ff == HX_SPACE && cq_cmd.is_ws) begin
                              hx_in = hx_ff;
                           end else if (hx_ff == HX_SPACE &&
                                        (cq_cmd.is_plus || cq_cmd.is_minus)) begin
                              neg_in = cq_cmd.is_minus;
                              hx_in  = HX_SIGN;
                           end else if (cq_cmd.is_zero) begin
                              hx_in = HX_ZERO;
                           end else if (cq_cmd.is_hex) begin
                              rem_in = rem_acc;
                              hx_in  = HX_DIGITS;
                           end else begin
                              hx_in = HX_STOP;
                           end
                        end
                        HX_ZERO: begin
                           if (cq_cmd.is_x) begin
                              hx_in = HX_PREFIX;
                           end else if (cq_cmd.is_hex) begin
                              rem_in = rem_acc;
                              hx_in  = HX_DIGITS;
                           end else begin
                              hx_in = HX_STOP;
                           end
                        end
                        HX_PREFIX, HX_DIGITS: begin
                           if (cq_cmd.is_hex) begin
                              rem_in = rem_acc;
                              hx_in  = HX_DIGITS;
                           end else begin
                              hx_in = HX_STOP;
                           end
                        end
                        default: hx_in = hx_ff;
                     endcase
                  end
               end
               PH_DATA: begin
                  valid_in = 1'b1;
                  rem_in   = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in    = PH_SIZELINE;
                     line_len_in = '0;
                     hx_in       = HX_SPACE;
                     neg_in      = 1'b0;
                  end
               end
               PH_TRAILER: begin
                  if (cq_cmd.is_nl) begin
                     if (saw_nl_ff) phase_in = PH_DONE;
                     else saw_nl_in = 1'b1;
                  end else if (!cq_cmd.is_cr) begin
                     saw_nl_in = 1'b0;
                  end
               end
               default: valid_in = 1'b0;
            endcase
         end
         KIND_EOS: begin
            unique case (phase_ff)
               PH_CLOSE, PH_TRAILER: phase_in = PH_DONE;
               PH_DONE, PH_ERROR:    phase_in = phase_ff;
               default:              phase_in = PH_ERROR;
            endcase
         end
         KIND_START: begin
            line_len_in = '0;
            hx_in       = HX_SPACE;
            neg_in      = 1'b0;
            saw_nl_in   = 1'b0;
            rem_in      = '0;
            if (cfg.chunked_mode) begin
               phase_in = PH_SIZELINE;
            end else if (cfg.length_known) begin
               rem_in   = start_len;
               phase_in = (start_len == '0) ? PH_DONE : PH_COUNTED;
            end else begin
               phase_in = PH_CLOSE;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   always_comb begin
      result.payload_byte  = valid_in ? cq_cmd.data_byte : 8'd0;
      result.payload_valid = valid_in;
      result.body_done     = (phase_in == PH_DONE);
      result.body_error    = (phase_in == PH_ERROR);
   end

   always_comb begin
      rq_wr_in  = rq_wr_ff;
      rq_rd_in  = rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (fire) begin
         rq_wr_in = (rq_wr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rq_wr_ff + QPTR_BITS'(1);
      end
      if (rsp_take) begin
         rq_rd_in = (rq_rd_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rq_rd_ff + QPTR_BITS'(1);
      end
      if (fire && !rsp_take) begin
         rq_cnt_in = rq_cnt_ff + QCNT_BITS'(1);
      end else if (!fire && rsp_take) begin
         rq_cnt_in = rq_cnt_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CLOSE;
         rem_ff      <= '0;
         line_len_ff <= '0;
         hx_ff       <= HX_SPACE;
         neg_ff      <= 1'b0;
         saw_nl_ff   <= 1'b0;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_cnt_ff   <= '0;
      end else begin
         if (fire) begin
            phase_ff    <= phase_in;
            rem_ff      <= rem_in;
            line_len_ff <= line_len_in;
            hx_ff       <= hx_in;
            neg_ff      <= neg_in;
            saw_nl_ff   <= saw_nl_in;
         end
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rq_mem_ff[rq_wr_ff] <= result;
      end
   end

   `ASSERT_IMPLIES(a_counted_nonzero, clock, reset, phase_ff == PH_COUNTED, rem_ff != '0)
   `ASSERT_NEXT(a_start_chunked, clock, reset, start_chunked, phase_ff == PH_SIZELINE)
   `ASSERT_IMPLIES(a_payload_phase, clock, reset, fire && valid_in, fwd_phase)

endmodule

@@ tb/http_body_deframer_test.sv @@
// ---------------------------------------------------------------------------
// http_body_deframer_test
// self-checking bench for the http body deframer: short directed bodies in
// close delimited, counted and chunked mode, then random bodies under four
// handshake pressure phases, each result checked against an in-bench model
// ---------------------------------------------------------------------------
module http_body_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hbd_pkg::*;

   localparam int          HALF_PERIOD   = 4;
   localparam int          RESET_CYCLES  = 10;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          RANDOM_ITEMS  = 850;
   localparam int          PRINT_LIMIT   = 100;
   localparam logic [1:0]  KIND_UNUSED   = 2'd3;
   localparam logic [63:0] SIZE_LIMIT    = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_push  = 1'b0;
   logic         req_full;
   req_item_type req_item  = '0;
   logic         rsp_empty;
   logic         rsp_pop   = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   // body state as the block should hold it
   cfg_type               csr_shadow;
   logic [2:0]            body_phase;
   logic [COUNT_BITS-1:0] bytes_left;
   logic [6:0]            line_chars;
   logic [2:0]            size_parse;
   logic                  size_minus;
   logic                  blank_armed;

   rsp_item_type body_rsp_q[$];   // deframed results still to come out
   rsp_item_type oldest_rsp;
   int           mismatch_count = 0;
   int unsigned  items_sent     = 0;
   int unsigned  quiet_cycles   = 0;
   int           send_idle_pct  = 0;
   int           pop_stall_pct  = 0;
   int           noise_pct      = 0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   http_body_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // body model
   // -------------------------------------------------------------------------

   function automatic void clear_size_line();
      line_chars = '0;
      size_parse = HX_SPACE;
      size_minus = 1'b0;
      bytes_left = '0;
   endfunction

   // registers only take effect here, at the start of a message
   function automatic void start_body();
      clear_size_line();
      blank_armed = 1'b0;
      if (csr_shadow.chunked_mode) begin
         body_phase = PH_SIZELINE;
      end else if (csr_shadow.length_known) begin
         if (64'(csr_shadow.content_length) > SIZE_LIMIT) bytes_left = SIZE_LIMIT[COUNT_BITS-1:0];
         else bytes_left = COUNT_BITS'(csr_shadow.content_length);
         body_phase = (bytes_left == 0) ? PH_DONE : PH_COUNTED;
      end else begin
         body_phase = PH_CLOSE;
      end
   endfunction

   function automatic rsp_item_type deframe_request(req_item_type rq);
      rsp_item_type res;
      logic         fwd;
      logic         take_digit;
      logic [7:0]   ch;
      logic [63:0]  wide;
      int           digit;
      fwd        = 1'b0;
      take_digit = 1'b0;
      ch         = rq.data_byte;
      if (ch >= "0" && ch <= "9") digit = int'(ch - "0");
      else if (ch >= "a" && ch <= "f") digit = int'(ch - "a") + 10;
      else if (ch >= "A" && ch <= "F") digit = int'(ch - "A") + 10;
      else digit = -1;
      case (rq.kind)
         KIND_BYTE: begin
            case (body_phase)
               PH_CLOSE: fwd = 1'b1;
               PH_COUNTED, PH_DATA: begin
                  fwd = 1'b1;
                  if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
                  if (bytes_left == 0) begin
                     // a counted body ends, a chunk goes back to its size line
                     if (body_phase == PH_COUNTED) begin
                        body_phase = PH_DONE;
                     end else begin
                        clear_size_line();
                        body_phase = PH_SIZELINE;
                     end
                  end
               end
               PH_SIZELINE: begin
                  if (ch == CHAR_NL) begin
                     // empty lines are skipped
                     if (line_chars != 0) begin
                        if (size_minus && bytes_left != 0) begin
                           body_phase = PH_ERROR;
                        end else if (bytes_left == 0) begin
                           body_phase  = PH_TRAILER;
                           blank_armed = 1'b1;
                        end else begin
                           body_phase = PH_DATA;
                        end
                        line_chars = '0;
                        size_parse = HX_SPACE;
                        size_minus = 1'b0;
                     end
                  end else if (ch != CHAR_CR && line_chars + 1 < LINE_CHARS) begin
                     line_chars = line_chars + 1'b1;
                     if (size_parse == HX_SPACE && (ch == CHAR_SP || ch == CHAR_TAB ||
                                                    ch == CHAR_VT || ch == CHAR_FF)) begin
                        // leading whitespace
                     end else if (size_parse == HX_SPACE &&
                                  (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
                        size_minus = (ch == CHAR_MINUS);
                        size_parse = HX_SIGN;
                     end else begin
                        case (size_parse)
                           HX_SPACE, HX_SIGN: begin
                              if (ch == CHAR_ZERO) size_parse = HX_ZERO;
                              else take_digit = 1'b1;
                           end
                           HX_ZERO: begin
                              if (ch == CHAR_X_LO || ch == CHAR_X_UP) size_parse = HX_PREFIX;
                              else take_digit = 1'b1;
                           end
                           HX_PREFIX, HX_DIGITS: take_digit = 1'b1;
                           default: ;
                        endcase
                        if (take_digit) begin
                           if (digit < 0) begin
                              size_parse = HX_STOP;
                           end else begin
                              // size saturates at the top of the counter
                              wide = 64'(bytes_left);
                              if (wide > (SIZE_LIMIT - 64'(digit)) / 16)
                                 bytes_left = SIZE_LIMIT[COUNT_BITS-1:0];
                              else
                                 bytes_left = COUNT_BITS'(wide * 16 + 64'(digit));
                              size_parse = HX_DIGITS;
                           end
                        end
                     end
                  end
               end
               PH_TRAILER: begin
                  if (ch == CHAR_NL) begin
                     if (blank_armed) body_phase = PH_DONE;
                     else blank_armed = 1'b1;
                  end else if (ch != CHAR_CR) begin
                     blank_armed = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         KIND_EOS: begin
            case (body_phase)
               PH_CLOSE, PH_TRAILER: body_phase = PH_DONE;
               PH_DONE, PH_ERROR: ;
               default: body_phase = PH_ERROR;
            endcase
         end
         KIND_START: start_body();
         default: ;
      endcase
      res.payload_byte  = fwd ? ch : 8'h00;
      res.payload_valid = fwd;
      res.body_done     = (body_phase == PH_DONE);
      res.body_error    = (body_phase == PH_ERROR);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // checking
   // -------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // register writes, accepted requests and results, all seen at the edge
   always @(posedge clock) begin
      if (reset) begin
         csr_shadow = '0;
         start_body();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CHUNKED_MODE:   csr_shadow.chunked_mode   = csr_wdata[0];
               CSR_LENGTH_KNOWN:   csr_shadow.length_known   = csr_wdata[0];
               CSR_CONTENT_LENGTH: csr_shadow.content_length = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (body_rsp_q.size() == 0) begin
               report_mismatch("result with no request behind it", 32'(rsp_item), 32'd0);
            end else begin
               oldest_rsp = body_rsp_q.pop_front();
               if (rsp_item.payload_byte !== oldest_rsp.payload_byte)
                  report_mismatch("payload_byte", 32'(rsp_item.payload_byte),
                                  32'(oldest_rsp.payload_byte));
               if (rsp_item.payload_valid !== oldest_rsp.payload_valid)
                  report_mismatch("payload_valid", 32'(rsp_item.payload_valid),
                                  32'(oldest_rsp.payload_valid));
               if (rsp_item.body_done !== oldest_rsp.body_done)
                  report_mismatch("body_done", 32'(rsp_item.body_done),
                                  32'(oldest_rsp.body_done));
               if (rsp_item.body_error !== oldest_rsp.body_error)
                  report_mismatch("body_error", 32'(rsp_item.body_error),
                                  32'(oldest_rsp.body_error));
            end
         end
         if (req_push && !req_full) body_rsp_q.push_back(deframe_request(req_item));
      end
   end

   // result side backpressure
   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // push stays high between back to back requests
   task automatic send_request(logic [1:0] rq_kind, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= '{kind: rq_kind, data_byte: b};
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   // a body byte, now and then preceded by a stray request of any kind
   task automatic send_byte(logic [7:0] b);
      if (noise_pct != 0 && $urandom_range(99) < noise_pct)
         send_request(2'($urandom_range(3)), 8'($urandom));
      send_request(KIND_BYTE, b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // every result is out and the block has gone quiet
   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (body_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mode bits carry random upper bits, only bit 0 counts
   task automatic set_body_mode(logic chunked, logic known, logic [31:0] len);
      drain_results();
      write_csr(CSR_CHUNKED_MODE, {31'($urandom), chunked});
      write_csr(CSR_LENGTH_KNOWN, {31'($urandom), known});
      write_csr(CSR_CONTENT_LENGTH, len);
   endtask

   // chunk size line: optional padding, sign, prefix, ndig hex digits of
   // size_val in mixed case, optional extension, then crlf or bare lf
   task automatic send_size_line(logic [63:0] size_val, int ndig, logic minus);
      int         pad;
      logic [3:0] nib;
      if ($urandom_range(29) == 0) pad = $urandom_range(60, 70);   // runs past the line limit
      else if ($urandom_range(3) == 0) pad = $urandom_range(1, 3);
      else pad = 0;
      repeat (pad) begin
         case ($urandom_range(3))
            0:       send_byte(CHAR_SP);
            1:       send_byte(CHAR_TAB);
            2:       send_byte(CHAR_VT);
            default: send_byte(CHAR_FF);
         endcase
      end
      if (minus) send_byte(CHAR_MINUS);
      else if ($urandom_range(6) == 0) send_byte(CHAR_PLUS);
      case ($urandom_range(9))
         0: begin send_byte(CHAR_ZERO); send_byte(CHAR_X_LO); end
         1: begin send_byte(CHAR_ZERO); send_byte(CHAR_X_UP); end
         2: send_byte(CHAR_ZERO);
         default: ;
      endcase
      // no digits at all still makes a nonempty line of size zero
      if (ndig == 0) send_text(";");
      for (int i = ndig - 1; i >= 0; i--) begin
         nib = size_val[4*i +: 4];
         if (nib < 10) send_byte(8'("0" + nib));
         else if ($urandom_range(1)) send_byte(8'("A" + nib - 10));
         else send_byte(8'("a" + nib - 10));
      end
      if ($urandom_range(4) == 0) begin
         send_text(";ext=");
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(8'h21, 8'h7E)));
      end
      if ($urandom_range(9) != 0) send_byte(CHAR_CR);
      send_byte(CHAR_NL);
   endtask

   // one message: registers, start, then a mostly well formed body
   task automatic send_random_body();
      int unsigned pick;
      int unsigned nbytes;
      logic [31:0] len;
      logic [63:0] size_val;
      logic [1:0]  tail_kind;
      pick = $urandom_range(7);
      case ($urandom_range(9))
         0:       len = 32'h0;
         1:       len = 32'hFFFF_FFFF;
         2:       len = $urandom;
         default: len = $urandom_range(1, 12);
      endcase
      set_body_mode(pick < 4, (pick < 4) ? 1'($urandom) : (pick < 6), len);
      noise_pct = ($urandom_range(4) == 0) ? 5 : 0;
      // bytes before the start still belong to the previous body
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      send_request(KIND_START, 8'($urandom));
      if (pick < 4) begin
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(3) == 0) begin
               if ($urandom_range(1)) send_byte(CHAR_CR);
               send_byte(CHAR_NL);
            end
            if ($urandom_range(29) == 0) begin
               // size wider than the counter, body cut short by end of stream
               size_val = {$urandom, $urandom};
               send_size_line(size_val, $urandom_range(9, 16), 1'b0);
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
               send_request(KIND_EOS, 8'($urandom));
               return;
            end
            size_val = 64'($urandom_range(1, 8));
            send_size_line(size_val, $urandom_range(1, 2), $urandom_range(19) == 0);
            repeat (size_val) send_byte(8'($urandom));
            if ($urandom_range(4) != 0) send_byte(CHAR_CR);
            send_byte(CHAR_NL);
         end
         // last chunk, trailers, then a blank line or end of stream
         send_size_line(64'h0, $urandom_range(0, 3), $urandom_range(3) == 0);
         repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(8'h21, 8'h7E)));
            send_byte(CHAR_CR);
            send_byte(CHAR_NL);
         end
         if ($urandom_range(3) == 0) begin
            send_request(KIND_EOS, 8'($urandom));
         end else begin
            send_byte(CHAR_CR);
            send_byte(CHAR_NL);
         end
      end else if (pick < 6) begin
         nbytes = (len <= 16 && $urandom_range(3) != 0) ? len : $urandom_range(0, 4);
         repeat (nbytes) send_byte(8'($urandom));
         if (nbytes != len || $urandom_range(1)) send_request(KIND_EOS, 8'($urandom));
      end else begin
         repeat ($urandom_range(0, 10)) send_byte(8'($urandom));
         if ($urandom_range(9) != 0) send_request(KIND_EOS, 8'($urandom));
      end
      // requests after the end are ignored
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            tail_kind = 2'($urandom_range(2));
            if (tail_kind == KIND_START) tail_kind = KIND_UNUSED;
            send_request(tail_kind, 8'($urandom));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // registers come out of reset as close delimited
   task automatic test_close_delimited();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_request(KIND_EOS, 8'h00);      // close is a normal end
      send_request(KIND_UNUSED, 8'hA5);
   endtask

   task automatic test_counted_body();
      set_body_mode(1'b0, 1'b1, 32'h0);
      send_request(KIND_START, 8'h00);    // zero length is done at once
      set_body_mode(1'b0, 1'b1, 32'hFFFF_FFFF);
      send_request(KIND_START, 8'hFF);
      send_byte(8'h5A);
      send_request(KIND_EOS, 8'h00);      // close before the count runs out
   endtask

   task automatic test_chunked_body();
      set_body_mode(1'b1, 1'b1, 32'h0);
      send_request(KIND_START, 8'h00);
      send_byte(CHAR_TAB);
      send_text("+0X2");
      send_byte(CHAR_CR);
      send_byte(CHAR_NL);
      send_byte(CHAR_NL);                 // chunk data passes a newline through
      send_byte(8'hFF);
      send_byte(CHAR_NL);                 // blank line between chunks
      send_text("-0");                    // minus zero is the last chunk
      send_byte(CHAR_NL);
      send_byte(CHAR_NL);                 // empty trailer line ends the body
      send_request(KIND_START, 8'h00);
      send_text("-1");                    // negative size
      send_byte(CHAR_NL);
   endtask

   task automatic test_random_bodies(int idle_pct, int stall_pct);
      int unsigned goal;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      goal = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < goal) send_random_body();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_close_delimited();
      test_counted_body();
      test_chunked_body();
      test_random_bodies(0, 0);
      test_random_bodies(83, 0);
      test_random_bodies(0, 83);
      test_random_bodies(26, 26);
      drain_results();
      if (mismatch_count == 0 && body_rsp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
